>>> design/row_top_k_select_macros.svh
// assertion macros for the row top-k selection block
`ifndef ROW_TOP_K_SELECT_MACROS_SVH
`define ROW_TOP_K_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define RTKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtks assertion failed");
`define RTKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtks assertion failed");
`else
`define RTKS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RTKS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/rtks_pkg.sv
// shared types and constants of the row top-k selection block
`timescale 1ns / 1ps

package rtks_pkg;

	localparam int SCORE_W    = 32;
	localparam int IDX_W      = 12;
	localparam int RANK_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_DIAGONAL  = 2'd2;

	localparam logic [4:0]  NEIGHBOR_COUNT_RST = 5'd5;
	localparam logic [12:0] ROW_LENGTH_RST     = 13'd4096;
	localparam logic        SKIP_DIAGONAL_RST  = 1'b1;

	typedef struct packed {
		logic insert;
		logic load;
		logic pop;
	} cmd_t;

endpackage

>>> design/rtks_datapath.sv
// kept list with parallel insertion and the result buffer
`timescale 1ns / 1ps

module rtks_datapath import rtks_pkg::*; #(
	parameter int MAX_K = 16,
	parameter int CW    = 12,
	parameter int KW    = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [SCORE_W-1:0] score,
	input  logic [CW-1:0]      col,
	input  logic [KW-1:0]      k_eff,
	output logic [KW-1:0]      new_count,
	output logic [SCORE_W-1:0] best_score,
	output logic [IDX_W-1:0]   column_index
);

	logic [SCORE_W-1:0] kept_score_q [MAX_K];
	logic [CW-1:0]      kept_col_q   [MAX_K];
	logic [KW-1:0]      kept_count_q;
	logic [SCORE_W-1:0] emit_score_q [MAX_K];
	logic [CW-1:0]      emit_col_q   [MAX_K];

	logic [SCORE_W-1:0] sh_score  [MAX_K];
	logic [CW-1:0]      sh_col    [MAX_K];
	logic [SCORE_W-1:0] new_score [MAX_K];
	logic [CW-1:0]      new_col   [MAX_K];
	logic [MAX_K-1:0]   ge;
	logic [MAX_K:0]     ge_ext;
	logic [KW-1:0]      kc;

	assign kc = (kept_count_q > k_eff) ? k_eff : kept_count_q;

	always_comb begin
		ge_ext[0] = 1'b1;
		sh_score[0] = score;
		sh_col[0] = col;
		for (int i = 0; i < MAX_K; i++) begin
			ge[i] = (KW'(i) < kc) && ($signed(kept_score_q[i]) >= $signed(score));
			ge_ext[i+1] = ge[i];
		end
		for (int i = 1; i < MAX_K; i++) begin
			sh_score[i] = kept_score_q[i-1];
			sh_col[i] = kept_col_q[i-1];
		end
		for (int i = 0; i < MAX_K; i++) begin
			if (ge[i]) begin
				new_score[i] = kept_score_q[i];
				new_col[i] = kept_col_q[i];
			end else if (ge_ext[i]) begin
				new_score[i] = score;
				new_col[i] = col;
			end else begin
				new_score[i] = sh_score[i];
				new_col[i] = sh_col[i];
			end
		end
	end

	// an insertion grows the list until it holds k entries
	always_comb begin
		if (cmd.insert && (kc < k_eff)) begin
			new_count = kc + KW'(1);
		end else begin
			new_count = kc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= '0;
		end else if (cmd.load) begin
			kept_count_q <= '0;
		end else begin
			kept_count_q <= new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_K; i++) begin
				kept_score_q[i] <= new_score[i];
				kept_col_q[i] <= new_col[i];
			end
		end
	end

	// result buffer, head entry drives the outputs
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_K; i++) begin
				emit_score_q[i] <= cmd.insert ? new_score[i] : kept_score_q[i];
				emit_col_q[i] <= cmd.insert ? new_col[i] : kept_col_q[i];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_K - 1; i++) begin
				emit_score_q[i] <= emit_score_q[i+1];
				emit_col_q[i] <= emit_col_q[i+1];
			end
		end
	end

	assign best_score = emit_score_q[0];
	assign column_index = IDX_W'(emit_col_q[0]);

endmodule

>>> design/rtks_controller.sv
// configuration, row and column counting, and result sequencing
`timescale 1ns / 1ps

module rtks_controller import rtks_pkg::*; #(
	parameter int MAX_K = 16,
	parameter int MAX_N = 4096,
	parameter int CW    = 12,
	parameter int KW    = 5,
	parameter int NW    = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  score_valid,
	output logic                  score_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [IDX_W-1:0]      row_index,
	output logic [RANK_W-1:0]     rank,
	output logic                  last_of_row,
	output cmd_t                  cmd,
	output logic [CW-1:0]         col,
	output logic [KW-1:0]         k_eff,
	input  logic [KW-1:0]         new_count
);

	localparam int EW  = NW + 1;
	localparam int KCW = (KW > 5) ? KW : 5;

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t          state_q;
	logic [KW-1:0]   remaining_q;
	logic [KW-1:0]   rank_q;
	logic [IDX_W-1:0] out_row_q;

	logic [4:0]      nc_q;
	logic [12:0]     rl_q;
	logic            skip_q;
	logic [CW-1:0]   col_q;
	logic [CW-1:0]   row_q;

	logic [NW-1:0]   n_eff;
	logic [KCW-1:0]  k_tmp;
	logic            last_col;
	logic            last_row;
	logic            accept;
	logic            diag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NEIGHBOR_COUNT_RST;
			rl_q <= ROW_LENGTH_RST;
			skip_q <= SKIP_DIAGONAL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NEIGHBOR_COUNT: nc_q <= cfg_data[4:0];
				REG_ROW_LENGTH:     rl_q <= cfg_data[12:0];
				REG_SKIP_DIAGONAL:  skip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_eff = (rl_q == 13'd0) ? NW'(1) : NW'(rl_q);
		if (n_eff > NW'(MAX_N)) begin
			n_eff = NW'(MAX_N);
		end
		k_tmp = (nc_q == 5'd0) ? KCW'(1) : KCW'(nc_q);
		if (k_tmp > KCW'(MAX_K)) begin
			k_tmp = KCW'(MAX_K);
		end
	end

	assign k_eff = KW'(k_tmp);
	assign last_col = (EW'(col_q) + EW'(1)) >= EW'(n_eff);
	assign last_row = (EW'(row_q) + EW'(1)) >= EW'(n_eff);
	assign diag = skip_q && (col_q == row_q);

	// the row's last score waits for the result buffer to drain
	assign score_ready = (state_q == ST_IDLE) || !last_col;
	assign accept = score_valid && score_ready;
	assign result_valid = (state_q == ST_EMIT);

	assign cmd.insert = accept && !diag;
	assign cmd.load = accept && last_col;
	assign cmd.pop = result_valid && result_ready;
	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : CW'(EW'(row_q) + EW'(1));
			end else begin
				col_q <= CW'(EW'(col_q) + EW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			remaining_q <= '0;
			rank_q <= '0;
			out_row_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && (new_count != '0)) begin
						state_q <= ST_EMIT;
						remaining_q <= new_count;
						rank_q <= '0;
						out_row_q <= IDX_W'(row_q);
					end
				end
				ST_EMIT: begin
					if (cmd.pop) begin
						remaining_q <= remaining_q - KW'(1);
						rank_q <= rank_q + KW'(1);
						if (remaining_q == KW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign row_index = out_row_q;
	assign rank = RANK_W'(rank_q);
	assign last_of_row = (remaining_q == KW'(1));

endmodule

>>> design/row_top_k_select.sv
// top level of the row top-k selection block
//
// channel   direction  handshake                    payload
// score     in         score_valid / score_ready    score
// result    out        result_valid / result_ready  best_score column_index row_index rank
//                                                   last_of_row
// config    in         cfg_write                    cfg_index cfg_data
//
// one score is taken per cycle while score_ready is high; the insertion compare across the kept list is combinational
// the row's last score stalls until the result buffer from the previous row has drained
// a row gives up to k results, one per cycle while result_ready is high, from a MAX_K-entry result buffer
// reset sets k = 5, row length 4096, diagonal skip on; no clearing pass is needed
`timescale 1ns / 1ps
`include "row_top_k_select_macros.svh"

module row_top_k_select import rtks_pkg::*; #(
	parameter int MAX_K = 16,
	parameter int MAX_N = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  score_valid,
	output logic                  score_ready,
	input  logic [SCORE_W-1:0]    score,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [SCORE_W-1:0]    best_score,
	output logic [IDX_W-1:0]      column_index,
	output logic [IDX_W-1:0]      row_index,
	output logic [RANK_W-1:0]     rank,
	output logic                  last_of_row
);

	localparam int CW  = $clog2(MAX_N);
	localparam int KW  = $clog2(MAX_K + 1);
	localparam int NW0 = $clog2(MAX_N + 1);
	localparam int NW  = (NW0 > 13) ? NW0 : 13;

	cmd_t          cmd;
	logic [CW-1:0] col;
	logic [KW-1:0] k_eff;
	logic [KW-1:0] new_count;

	rtks_controller #(
		.MAX_K(MAX_K),
		.MAX_N(MAX_N),
		.CW(CW),
		.KW(KW),
		.NW(NW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.score_valid(score_valid),
		.score_ready(score_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.row_index(row_index),
		.rank(rank),
		.last_of_row(last_of_row),
		.cmd(cmd),
		.col(col),
		.k_eff(k_eff),
		.new_count(new_count)
	);

	rtks_datapath #(
		.MAX_K(MAX_K),
		.CW(CW),
		.KW(KW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.score(score),
		.col(col),
		.k_eff(k_eff),
		.new_count(new_count),
		.best_score(best_score),
		.column_index(column_index)
	);

	`RTKS_ASSERT_IMPL(a_first_rank_zero, clk, arst_n, $rose(result_valid), rank == '0)
	`RTKS_ASSERT_NEXT(a_rank_steps, clk, arst_n, result_valid && result_ready && !last_of_row, result_valid && (rank == RANK_W'($past(rank) + 4'd1)))
	`RTKS_ASSERT_NEXT(a_row_done, clk, arst_n, result_valid && result_ready && last_of_row, !result_valid)
	`RTKS_ASSERT_IMPL(a_no_load_busy, clk, arst_n, cmd.load, !result_valid)

endmodule
